// ===== rtl/sce_pkg.sv =====
// shared types and constants for the set container encoder
package sce_pkg;

    localparam int MAX_BITS_DEF  = 4096;
    localparam int MAX_ARRAY_DEF = 64;

    localparam int POS_W   = 12;
    localparam int COUNT_W = 13;
    localparam int RUNS_W  = 12;
    localparam int WORD_W  = 64;
    localparam int LIMIT_W = 7;
    localparam int UNIV_W  = 13;
    localparam int IDX_W   = 7;

    localparam int CFG_IW = 1;
    localparam int CFG_DW = 13;

    localparam logic [CFG_IW-1:0] CFG_ARRAY_LIMIT   = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_UNIVERSE_BITS = 1'b1;

    localparam logic [LIMIT_W-1:0] ARRAY_LIMIT_RST   = 7'd32;
    localparam logic [UNIV_W-1:0]  UNIVERSE_BITS_RST = 13'd4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
    localparam logic [RUNS_W-1:0]  RUNS_MAX  = 12'hFFF;

    typedef enum logic [2:0] {
        TAG_BITMAP = 3'd0,
        TAG_ARRAY  = 3'd1,
        TAG_RUNS   = 3'd2,
        TAG_FULL   = 3'd3,
        TAG_EMPTY  = 3'd4
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RD,
        ST_CAP,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/set_container_encoder.sv =====
// set container encoder: per-row container selection and payload emission
// flow: after a row's last beat the decide state registers an empty or full result; array and
//   bitmap words follow, one read and one capture state each; run words leave as each run closes
// input: 1 beat per cycle in a row; input stalls from row end until the row's last word is
//   loaded (runs add a flush state), plus any output stall
// reset: control, counts and config to reset values, bitmap valid bits cleared, buffer not reset
module set_container_encoder #(
    parameter int MAX_BITS  = sce_pkg::MAX_BITS_DEF,
    parameter int MAX_ARRAY = sce_pkg::MAX_ARRAY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [sce_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [sce_pkg::CFG_DW-1:0]   cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sce_pkg::POS_W-1:0]    position,
    input  logic                         row_empty,
    input  logic                         last,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   tag,
    output logic [sce_pkg::WORD_W-1:0]   word,
    output logic                         word_valid,
    output logic                         last_res
);
    import sce_pkg::*;

    // bitmap store geometry, one 64-bit word per 64 positions
    localparam int BM_WORDS = MAX_BITS / 64;
    localparam int BM_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
    // position buffer geometry
    localparam int BA_W     = (MAX_ARRAY > 1) ? $clog2(MAX_ARRAY) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] array_limit_reg;
    logic [UNIV_W-1:0]  universe_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_limit_reg   <= ARRAY_LIMIT_RST;
            universe_bits_reg <= UNIVERSE_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ARRAY_LIMIT:   array_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_UNIVERSE_BITS: universe_bits_reg <= cfg_data[UNIV_W-1:0];
                default:           ;
            endcase
        end
    end

    // effective limit and universe after clamping
    logic [LIMIT_W-1:0] limit_eff;
    logic [UNIV_W-1:0]  ub_eff;
    logic [UNIV_W-1:0]  ub_round;
    logic [IDX_W-1:0]   nw;

    assign limit_eff = (array_limit_reg > LIMIT_W'(MAX_ARRAY)) ? LIMIT_W'(MAX_ARRAY)
                                                               : array_limit_reg;
    always_comb
    begin
        if (universe_bits_reg > UNIV_W'(MAX_BITS))
            ub_eff = UNIV_W'(MAX_BITS);
        else if (universe_bits_reg == '0)
            ub_eff = UNIV_W'(1);
        else
            ub_eff = universe_bits_reg;
    end
    // number of bitmap words to emit: ceil(ub / 64), ub is at most 4096 so no carry out
    assign ub_round = ub_eff + UNIV_W'(63);
    assign nw       = ub_round[UNIV_W-1:6];

    // ------------------------------------------------------------------
    // handshake and state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic in_accept;
    logic pos_take;
    logic slot_free;
    logic out_valid_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign pos_take  = in_accept && !row_empty;
    assign slot_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // row counters
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] row_count_reg;
    logic [RUNS_W-1:0]  run_count_reg;
    logic [POS_W-1:0]   prev_pos_reg;
    logic               first_seen_reg;
    logic               new_run;
    logic               row_clear;

    // a run begins at the first position and at any break in +1 steps
    assign new_run = !first_seen_reg ||
                     ({1'b0, position} != ({1'b0, prev_pos_reg} + (POS_W+1)'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            run_count_reg  <= '0;
            prev_pos_reg   <= '0;
            first_seen_reg <= 1'b0;
        end
        else if (row_clear)
        begin
            row_count_reg  <= '0;
            run_count_reg  <= '0;
            prev_pos_reg   <= '0;
            first_seen_reg <= 1'b0;
        end
        else if (pos_take)
        begin
            if (new_run && (run_count_reg < RUNS_MAX))
                run_count_reg <= run_count_reg + RUNS_W'(1);
            if (row_count_reg < COUNT_MAX)
                row_count_reg <= row_count_reg + COUNT_W'(1);
            prev_pos_reg   <= position;
            first_seen_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // emission control registers
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    tag_t               mode_reg, mode_next;

    // ------------------------------------------------------------------
    // position buffer: written at the running count, read during emission
    // ------------------------------------------------------------------
    logic [POS_W-1:0] buf_mem [MAX_ARRAY];
    logic [POS_W-1:0] buf_rd_reg;

    always_ff @(posedge clk)
    begin
        if (pos_take && (row_count_reg < COUNT_W'(MAX_ARRAY)))
            buf_mem[row_count_reg[BA_W-1:0]] <= position;
        buf_rd_reg <= buf_mem[idx_reg[BA_W-1:0]];
    end

    // ------------------------------------------------------------------
    // bitmap store: read-modify-write, one stage deep
    //   cycle of accept: read the word; next cycle: or in the bit, write back
    //   a write landing on the same edge as the read is forwarded from lw_*
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]   bm_mem [BM_WORDS];
    logic [WORD_W-1:0]   bm_rd_reg;
    logic                bm_rd_vld_reg;
    logic [BM_WORDS-1:0] bm_vld_reg;
    logic [BM_AW-1:0]    bm_raddr;
    logic                in_range;

    logic                s1_valid_reg;
    logic [BM_AW-1:0]    s1_addr_reg;
    logic [WORD_W-1:0]   s1_mask_reg;
    logic                lw_valid_reg;
    logic [BM_AW-1:0]    lw_addr_reg;
    logic [WORD_W-1:0]   lw_data_reg;
    logic [WORD_W-1:0]   bm_word;
    logic [WORD_W-1:0]   s1_base;
    logic [WORD_W-1:0]   s1_wdata;

    // positions beyond the store are counted but set no bit
    assign in_range = ({1'b0, position[POS_W-1:6]} < 7'(BM_WORDS));

    // emission owns the read port while it walks the words
    assign bm_raddr = (state_reg == ST_RD || state_reg == ST_CAP) ? idx_reg[BM_AW-1:0]
                                                                  : position[6 +: BM_AW];

    // a word never written in this row reads as zero
    assign bm_word  = bm_rd_vld_reg ? bm_rd_reg : '0;
    assign s1_base  = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : bm_word;
    assign s1_wdata = s1_base | s1_mask_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            bm_mem[s1_addr_reg] <= s1_wdata;
        bm_rd_reg     <= bm_mem[bm_raddr];
        bm_rd_vld_reg <= bm_vld_reg[bm_raddr];
        s1_addr_reg   <= position[6 +: BM_AW];
        s1_mask_reg   <= WORD_W'(1) << position[5:0];
        if (s1_valid_reg)
        begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= s1_wdata;
        end
    end

    // row clear wins over a write-back on the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            bm_vld_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= pos_take && in_range;
            if (row_clear)
            begin
                lw_valid_reg <= 1'b0;
                bm_vld_reg   <= '0;
            end
            else if (s1_valid_reg)
            begin
                lw_valid_reg             <= 1'b1;
                bm_vld_reg[s1_addr_reg]  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // run tracker used while emitting run containers
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   run_start_reg, run_start_next;
    logic [IDX_W-1:0]   run_len_reg, run_len_next;
    logic [POS_W-1:0]   run_prev_reg, run_prev_next;
    logic [WORD_W-1:0]  run_word;

    // run word: start in 15..0, length in 31..16
    assign run_word = WORD_W'({9'd0, run_len_reg, 4'd0, run_start_reg});

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    tag_t              tag_reg, o_tag;
    logic [WORD_W-1:0] word_reg, o_word;
    logic              word_valid_reg, o_word_valid;
    logic              last_res_reg, o_last_res;
    logic              out_load;

    // ------------------------------------------------------------------
    // sequencer: decide container, then walk buffer or bitmap
    // ------------------------------------------------------------------
    logic is_last_idx;
    logic runs_fit;

    assign is_last_idx = (idx_reg == (cnt_reg - IDX_W'(1)));
    assign runs_fit    = ({run_count_reg, 2'b00} <= {1'b0, row_count_reg});

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        run_prev_next  = run_prev_reg;
        out_load       = 1'b0;
        o_tag          = TAG_EMPTY;
        o_word         = '0;
        o_word_valid   = 1'b0;
        o_last_res     = 1'b0;
        row_clear      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last)
                    state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (row_count_reg == '0 || row_count_reg == ub_eff)
                begin
                    // single tag-only result
                    if (slot_free)
                    begin
                        out_load   = 1'b1;
                        o_tag      = (row_count_reg == '0) ? TAG_EMPTY : TAG_FULL;
                        o_last_res = 1'b1;
                        row_clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (row_count_reg <= COUNT_W'(limit_eff))
                begin
                    mode_next  = runs_fit ? TAG_RUNS : TAG_ARRAY;
                    cnt_next   = row_count_reg[IDX_W-1:0];
                    idx_next   = '0;
                    state_next = ST_RD;
                end
                else
                begin
                    mode_next  = TAG_BITMAP;
                    cnt_next   = nw;
                    idx_next   = '0;
                    state_next = ST_RD;
                end
            end

            ST_RD:
            begin
                state_next = ST_CAP;
            end

            ST_CAP:
            begin
                if (slot_free)
                begin
                    case (mode_reg)
                        TAG_BITMAP:
                        begin
                            out_load     = 1'b1;
                            o_tag        = TAG_BITMAP;
                            o_word       = bm_word;
                            o_word_valid = 1'b1;
                            o_last_res   = is_last_idx;
                        end
                        TAG_ARRAY:
                        begin
                            out_load     = 1'b1;
                            o_tag        = TAG_ARRAY;
                            o_word       = WORD_W'(buf_rd_reg);
                            o_word_valid = 1'b1;
                            o_last_res   = is_last_idx;
                        end
                        TAG_RUNS:
                        begin
                            if (idx_reg == '0)
                            begin
                                run_start_next = buf_rd_reg;
                                run_len_next   = IDX_W'(1);
                            end
                            else if ({1'b0, buf_rd_reg} ==
                                     ({1'b0, run_prev_reg} + (POS_W+1)'(1)))
                            begin
                                run_len_next = run_len_reg + IDX_W'(1);
                            end
                            else
                            begin
                                // break: close the current run
                                out_load       = 1'b1;
                                o_tag          = TAG_RUNS;
                                o_word         = run_word;
                                o_word_valid   = 1'b1;
                                run_start_next = buf_rd_reg;
                                run_len_next   = IDX_W'(1);
                            end
                            run_prev_next = buf_rd_reg;
                        end
                        default: ;
                    endcase

                    if (is_last_idx)
                    begin
                        if (mode_reg == TAG_RUNS)
                            state_next = ST_FLUSH;
                        else
                        begin
                            row_clear  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_FLUSH:
            begin
                // final open run closes the row
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    o_tag        = TAG_RUNS;
                    o_word       = run_word;
                    o_word_valid = 1'b1;
                    o_last_res   = 1'b1;
                    row_clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            mode_reg      <= TAG_BITMAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        run_prev_reg  <= run_prev_next;
        if (out_load)
        begin
            tag_reg        <= o_tag;
            word_reg       <= o_word;
            word_valid_reg <= o_word_valid;
            last_res_reg   <= o_last_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tag        = tag_reg;
    assign word       = word_reg;
    assign word_valid = word_valid_reg;
    assign last_res   = last_res_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the set container encoder with a row-level container predictor
module tb_top;
    import sce_pkg::*;

    // run bounds
    localparam int LIMIT_CYCLES  = 3000000;
    localparam int SETTLE_CYCLES = 8;      // block may still be flushing after its last word
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off for the fill test
    localparam int RANDOM_ITEMS  = 70;

    typedef struct {
        tag_t              tag;
        logic [WORD_W-1:0] word;
        logic              word_valid;
        logic              last_res;
    } container_word_t;

    typedef int unsigned pos_list_t[$];

    // dut signals, all inputs known from time zero
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [CFG_IW-1:0]   cfg_index  = '0;
    logic [CFG_DW-1:0]   cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [POS_W-1:0]    position   = '0;
    logic                row_empty  = 1'b0;
    logic                last       = 1'b0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [2:0]          tag;
    logic [WORD_W-1:0]   word;
    logic                word_valid;
    logic                last_res;

    // predictor copy of the block's row state and registers
    logic [POS_W-1:0]    row_positions [64];
    logic [WORD_W-1:0]   row_bitmap    [64];
    int unsigned         members;
    int unsigned         runs_open;
    int unsigned         prev_pos;
    bit                  have_prev;
    int unsigned         cur_limit    = ARRAY_LIMIT_RST;
    int unsigned         cur_universe = UNIVERSE_BITS_RST;

    container_word_t     pending_words[$];
    int                  mismatches  = 0;
    int unsigned         beats_taken = 0;

    // pacing controls, written only by the stimulus process
    bit                  tx_steady = 1'b0;
    bit                  rx_steady = 1'b0;
    int                  hold_seq  = 0;

    // receiver-side pacing state, written only by the receiver process
    int                  stall_left = 0;
    int                  hold_left  = 0;
    int                  hold_seen  = 0;

    set_container_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .position   (position),
        .row_empty  (row_empty),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tag        (tag),
        .word       (word),
        .word_valid (word_valid),
        .last_res   (last_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // container predictor
    // ---------------------------------------------------------------

    task automatic clear_row();
        for (int k = 0; k < 64; k++)
        begin
            row_bitmap[k] = '0;
        end
        members   = 0;
        runs_open = 0;
        prev_pos  = 0;
        have_prev = 1'b0;
    endtask

    task automatic push_word(input tag_t t, input logic [WORD_W-1:0] w,
                             input logic wv, input logic lr);
        container_word_t cw;
        cw.tag        = t;
        cw.word       = w;
        cw.word_valid = wv;
        cw.last_res   = lr;
        pending_words.insert(pending_words.size(), cw);
    endtask

    // fold one accepted beat into the row; at row end queue the container words
    task automatic encode_beat(input logic [POS_W-1:0] pos, input logic emp, input logic lst);
        int unsigned lim;
        int unsigned ub;
        int unsigned nw;
        int unsigned i;
        int unsigned j;
        if (!emp)
        begin
            // a run opens at the first position and at every break in adjacency
            if (!have_prev || pos != prev_pos + 1)
            begin
                if (runs_open < RUNS_MAX)
                    runs_open++;
            end
            if (members < 64)
                row_positions[members] = pos;
            if (members < COUNT_MAX)
                members++;
            row_bitmap[pos[11:6]][pos[5:0]] = 1'b1;
            prev_pos  = pos;
            have_prev = 1'b1;
        end
        if (!lst)
            return;

        // effective limits: array limit capped, universe clamped to 1..MAX_BITS
        lim = (cur_limit > MAX_ARRAY_DEF) ? MAX_ARRAY_DEF : cur_limit;
        ub  = (cur_universe > MAX_BITS_DEF) ? MAX_BITS_DEF : cur_universe;
        if (ub == 0)
            ub = 1;

        if (members == 0)
            push_word(TAG_EMPTY, '0, 1'b0, 1'b1);
        else if (members == ub)
            push_word(TAG_FULL, '0, 1'b0, 1'b1);
        else if (members <= lim)
        begin
            if (runs_open * 4 <= members)
            begin
                i = 0;
                while (i < members)
                begin
                    j = i;
                    while (j + 1 < members && row_positions[j + 1] == row_positions[j] + 1)
                        j++;
                    push_word(TAG_RUNS, {32'd0, 16'(j - i + 1), 4'd0, row_positions[i]},
                              1'b1, j + 1 >= members);
                    i = j + 1;
                end
            end
            else
            begin
                for (i = 0; i < members; i++)
                    push_word(TAG_ARRAY, {52'd0, row_positions[i]}, 1'b1, i + 1 == members);
            end
        end
        else
        begin
            nw = (ub + 63) / 64;
            for (i = 0; i < nw; i++)
                push_word(TAG_BITMAP, row_bitmap[i], 1'b1, i + 1 == nw);
        end
        clear_row();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, long hold-off on request, result check
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_word();
        container_word_t exp_w;
        if (pending_words.size() == 0)
        begin
            $display("%0t: unexpected beat, expected none actual tag %0d word %h",
                     $time, tag, word);
            mismatches++;
            return;
        end
        exp_w = pending_words.pop_front();
        check_field("tag", exp_w.tag, tag);
        check_field("word", exp_w.word, word);
        check_field("word_valid", exp_w.word_valid, word_valid);
        check_field("last_res", exp_w.last_res, last_res);
    endtask

    always @(posedge clk)
    begin : receiver
        int r;
        // values seen here are the ones from before this edge
        if (rst_n && out_valid === 1'b1 && !out_stall)
            check_word();

        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_seq != hold_seen)
        begin
            // long hold-off so the block backs up into its input
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (rx_steady)
            out_stall <= 1'b0;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                out_stall <= 1'b0;
            else
            begin
                if (r < 93)
                    stall_left = $urandom_range(1, 3);
                else if (r < 99)
                    stall_left = $urandom_range(4, 10);
                else
                    stall_left = $urandom_range(11, 40);
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // mostly back-to-back beats, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // offer one beat, hold it until accepted, then predict
    task automatic send_item(input logic [POS_W-1:0] pos, input logic emp, input logic lst);
        int gap;
        in_valid  <= 1'b1;
        position  <= pos;
        row_empty <= emp;
        last      <= lst;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        encode_beat(pos, emp, lst);
        if (!emp || lst)
            beats_taken++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one row; optional filler beats and an empty-flagged closing beat
    task automatic send_row(input pos_list_t q, input bit end_on_empty, input int filler_pct);
        foreach (q[k])
        begin
            if ($urandom_range(0, 99) < filler_pct)
                send_item(POS_W'($urandom), 1'b1, 1'b0);
            send_item(q[k][POS_W-1:0], 1'b0, !end_on_empty && k == q.size() - 1);
        end
        if (end_on_empty || q.size() == 0)
            send_item(POS_W'($urandom), 1'b1, 1'b1);
    endtask

    // ascending positions with duplicates, adjacent steps and jumps
    function automatic pos_list_t make_sorted(int n, int max_step);
        pos_list_t   q;
        int unsigned p;
        int          r;
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1000);
        for (int k = 0; k < n; k++)
        begin
            if (k > 0)
            begin
                r = $urandom_range(0, 9);
                if (r >= 6)
                    p += $urandom_range(1, max_step);
                else if (r != 0)
                    p += 1;
                if (p > 4095)
                    p = 4095;
            end
            q.insert(q.size(), p);
        end
        return q;
    endfunction

    // block idle: nothing pending and the flush given time to finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IW-1:0] idx, input int unsigned value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DW-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ARRAY_LIMIT)
            cur_limit = value[LIMIT_W-1:0];
        else
            cur_universe = value[UNIV_W-1:0];
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // each container kind under the reset settings
    task automatic test_container_kinds();
        send_item(12'd123, 1'b1, 1'b1);                    // lone empty beat ends the row
        send_row('{0, 7, 4095}, 1'b0, 0);                  // array, both position extremes
        send_row('{10, 11, 12, 13}, 1'b0, 0);              // one run
        send_item(12'd55, 1'b1, 1'b0);                     // ignored filler
        send_row('{100, 101, 102, 103}, 1'b1, 0);          // runs, closed by an empty beat
        send_row('{9, 9}, 1'b0, 0);                        // duplicate opens a new run
        send_row('{200, 201, 203, 204, 205, 206, 207, 208}, 1'b0, 0); // two runs
    endtask

    // bitmap length, positions past the universe, full rows, clamped registers
    task automatic test_bitmap_and_universe();
        write_cfg(CFG_ARRAY_LIMIT, 0);
        send_row('{0, 63, 64}, 1'b0, 0);                   // full-width bitmap
        write_cfg(CFG_UNIVERSE_BITS, 100);
        send_row('{1, 99, 4000}, 1'b0, 0);                 // two words, far bit not shown
        write_cfg(CFG_UNIVERSE_BITS, 65);
        send_row('{64}, 1'b0, 0);
        write_cfg(CFG_UNIVERSE_BITS, 1);
        send_row('{7}, 1'b0, 0);                           // count equals universe
        write_cfg(CFG_UNIVERSE_BITS, 0);
        send_row('{5}, 1'b0, 0);                           // zero universe acts as one
        write_cfg(CFG_UNIVERSE_BITS, 8191);
        write_cfg(CFG_ARRAY_LIMIT, 127);
        send_row('{4093, 4094, 4095}, 1'b0, 0);
    endtask

    // receiver holds off while rows keep coming, block must stall its input
    task automatic test_output_backpressure();
        write_cfg(CFG_ARRAY_LIMIT, 64);
        tx_steady = 1'b1;
        hold_seq++;
        repeat (4) send_row(make_sorted(12, 4), 1'b0, 0);
        tx_steady = 1'b0;
    endtask

    task automatic send_random_row();
        pos_list_t   q;
        int unsigned lim;
        int unsigned ub;
        int unsigned p;
        int unsigned len;
        int          kind;
        bit          end_empty;
        lim  = (cur_limit > MAX_ARRAY_DEF) ? MAX_ARRAY_DEF : cur_limit;
        ub   = (cur_universe > MAX_BITS_DEF) ? MAX_BITS_DEF : cur_universe;
        if (ub == 0)
            ub = 1;
        kind      = $urandom_range(0, 99);
        end_empty = ($urandom_range(0, 9) == 0);
        if (kind < 8)
        begin
            // empty row, q stays empty
        end
        else if (kind < 18 && ub <= 70)
        begin
            p = $urandom_range(0, 4096 - ub);
            for (int k = 0; k < ub; k++)
                q.insert(q.size(), p + k);
        end
        else if (kind < 40)
        begin
            // a few blocks of adjacent positions
            p = $urandom_range(0, 3000);
            repeat ($urandom_range(1, 3))
            begin
                len = $urandom_range(2, 8);
                for (int k = 0; k < len; k++)
                    q.insert(q.size(), p + k);
                p += len + $urandom_range(2, 50);
            end
        end
        else if (kind < 55)
            q = make_sorted(lim + 1 + $urandom_range(0, 3), 64);   // just past the limit
        else if (kind < 62 && lim > 0)
            q = make_sorted(lim, 8);                               // right at the limit
        else if (kind < 88)
            q = make_sorted($urandom_range(1, 10), 300);
        else
        begin
            // noise: unordered positions
            repeat ($urandom_range(1, 8))
                q.insert(q.size(), $urandom_range(0, 4095));
        end
        send_row(q, end_empty, 10);
    endtask

    // phases of random settings, each with a few random rows
    task automatic test_random_rows();
        int unsigned base;
        int unsigned lim;
        int unsigned ub;
        base = beats_taken;
        while (beats_taken - base < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       lim = 0;
                1:       lim = 64;
                2:       lim = 127;
                3:       lim = $urandom_range(1, 8);
                default: lim = $urandom_range(0, 80);
            endcase
            case ($urandom_range(0, 6))
                0:       ub = 0;
                1:       ub = 1;
                2:       ub = 4096;
                3:       ub = 8191;
                4, 5:    ub = $urandom_range(2, 70);
                default: ub = $urandom_range(0, 8191);
            endcase
            write_cfg(CFG_ARRAY_LIMIT, lim);
            write_cfg(CFG_UNIVERSE_BITS, ub);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) send_random_row();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // sequence and end of run
    // ---------------------------------------------------------------

    initial
    begin
        clear_row();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_container_kinds();
        test_bitmap_and_universe();
        test_output_backpressure();
        test_random_rows();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // cycle counter watchdog
    initial
    begin
        for (int cyc = 0; cyc < LIMIT_CYCLES; cyc++)
            @(posedge clk);
        $display("%0t: timeout with %0d words pending", $time, pending_words.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
